/* src/rau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions of the rational arithmetic unit
// Word constants, mode codes, datapath commands and status bundle.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS = 64;

  localparam logic [63:0]  WMASK = {64{1'b1}} >> (64 - WORD_BITS);
  localparam logic [127:0] DMASK = {128{1'b1}} >> (128 - 2 * WORD_BITS);

  localparam logic [2:0] MODE_SUM  = 3'd0;
  localparam logic [2:0] MODE_DIFF = 3'd1;
  localparam logic [2:0] MODE_PROD = 3'd2;
  localparam logic [2:0] MODE_QUOT = 3'd3;
  localparam logic [2:0] MODE_CMP  = 3'd4;
  localparam logic [2:0] MODE_EQ   = 3'd5;

  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_MOV_PX,
    OP_MOV_PY,
    OP_ADD,
    OP_SUB,
    OP_FIT,
    OP_GCD,
    OP_DIV,
    OP_MOV_Q,
    OP_LD_A,
    OP_LD_B,
    OP_LD_BSW,
    OP_LD_DEN,
    OP_ST_A,
    OP_ST_B,
    OP_OUT_RAT,
    OP_OUT_A,
    OP_OUT_ZERO,
    OP_OUT_ORD,
    OP_OUT_EQ
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_AN_BD,
    MS_BN_AD,
    MS_AD_BD,
    MS_AN_BN,
    MS_AN_YL,
    MS_BN_XL
  } mul_sel_e;

  typedef struct packed {
    dp_op_e            op;
    mul_sel_e          msel;
    logic              sgn;
    logic signed [1:0] ord;
    logic              eqb;
  } cmd_t;

  typedef struct packed {
    logic a_sign;
    logic b_sign;
    logic a_nan;
    logic a_inf;
    logic a_zero;
    logic b_nan;
    logic b_inf;
    logic b_zero;
    logic num_eq;
    logic den_eq;
    logic x_lt_y;
    logic x_zero;
    logic y_zero;
    logic y_gt_p;
    logic y_lt_p;
    logic g_zero;
    logic mul_busy;
    logic gcd_busy;
    logic div_busy;
  } status_t;

endpackage
`default_nettype wire

/* src/rau_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_in_if: operand channel
// Operation code and two sign-magnitude rationals, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] a_num;
  logic [63:0] a_den;
  logic        a_sign;
  logic [63:0] b_num;
  logic [63:0] b_den;
  logic        b_sign;

  modport source (
    output valid, mode, a_num, a_den, a_sign, b_num, b_den, b_sign,
    input  ready
  );
  modport sink (
    input  valid, mode, a_num, a_den, a_sign, b_num, b_den, b_sign,
    output ready
  );
endinterface
`default_nettype wire

/* src/rau_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_out_if: result channel
// Reduced rational, overflow, compare order and equals flag.
// ----------------------------------------------------------------------------
interface rau_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       res_num;
  logic [63:0]       res_den;
  logic              res_sign;
  logic              overflow;
  logic signed [1:0] order;
  logic              equal;

  modport source (
    output valid, res_num, res_den, res_sign, overflow, order, equal,
    input  ready
  );
  modport sink (
    input  valid, res_num, res_den, res_sign, overflow, order, equal,
    output ready
  );
endinterface
`default_nettype wire

/* src/rau_gcd.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// One shift or one subtract per cycle on 128-bit operands.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] a_i,
  input  logic [127:0] b_i,
  output logic         busy_o,
  output logic [127:0] g_o
);

  typedef enum logic [2:0] {
    G_IDLE,
    G_TWOS,
    G_AODD,
    G_LOOP,
    G_SHL
  } gcd_state_e;

  gcd_state_e   state_q;
  logic [127:0] a_q;
  logic [127:0] b_q;
  logic [6:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        G_IDLE: begin
          if (start_i) begin
            cnt_q <= '0;
            if (a_i == '0) begin
              a_q <= b_i;
            end else if (b_i == '0) begin
              a_q <= a_i;
            end else begin
              a_q     <= a_i;
              b_q     <= b_i;
              state_q <= G_TWOS;
            end
          end
        end
        G_TWOS: begin
          // strip common factors of two, counted for the final shift
          if (!(a_q[0] | b_q[0])) begin
            a_q   <= a_q >> 1;
            b_q   <= b_q >> 1;
            cnt_q <= cnt_q + 7'd1;
          end else begin
            state_q <= G_AODD;
          end
        end
        G_AODD: begin
          if (!a_q[0]) a_q <= a_q >> 1;
          else         state_q <= G_LOOP;
        end
        G_LOOP: begin
          if (b_q == '0) begin
            state_q <= G_SHL;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (a_q > b_q) begin
            a_q <= b_q;
            b_q <= a_q - b_q;
          end else begin
            b_q <= b_q - a_q;
          end
        end
        G_SHL: begin
          if (cnt_q == '0) begin
            state_q <= G_IDLE;
          end else begin
            a_q   <= a_q << 1;
            cnt_q <= cnt_q - 7'd1;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != G_IDLE);
  assign g_o    = a_q;

endmodule
`default_nettype wire

/* src/rau_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_div: restoring divider
// 128-bit quotient, one bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] n_i,
  input  logic [127:0] d_i,
  output logic         busy_o,
  output logic [127:0] q_o
);

  logic         busy_q;
  logic [6:0]   cnt_q;
  logic [127:0] n_q;
  logic [127:0] r_q;
  logic [127:0] d_q;
  logic [128:0] rs;
  logic [128:0] rdiff;
  logic         ge;

  always_comb begin
    rs    = {r_q, n_q[127]};
    rdiff = rs - {1'b0, d_q};
    ge    = (rs >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd127;
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      cnt_q <= cnt_q - 7'd1;
    end
  end

  // quotient bits shift into the dividend register as it empties
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? rdiff[127:0] : rs[127:0];
      n_q <= {n_q[126:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign q_o    = n_q;

endmodule
`default_nettype wire

/* src/rau_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dp: datapath
// Operand and working registers, sequential 64x64 multiplier, gcd unit,
// two dividers and the output register.
// ----------------------------------------------------------------------------
module rau_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        a_num_i,
  input  logic [63:0]        a_den_i,
  input  logic               a_sign_i,
  input  logic [63:0]        b_num_i,
  input  logic [63:0]        b_den_i,
  input  logic               b_sign_i,
  input  rau_pkg::cmd_t      cmd_i,
  output rau_pkg::status_t   status_o,
  output logic [63:0]        res_num_o,
  output logic [63:0]        res_den_o,
  output logic               res_sign_o,
  output logic               overflow_o,
  output logic signed [1:0]  order_o,
  output logic               equal_o
);

  logic [63:0]  an_q, ad_q, bn_q, bd_q;
  logic         as_q, bs_q;
  logic [127:0] x_q, y_q, p_q;
  logic         ovf_q;

  // multiplier
  logic         mbusy_q;
  logic [2:0]   mcnt_q;
  logic [63:0]  ma_q, mb_q, ma_sel, mb_sel;
  logic [31:0]  ma_part, mb_part;
  logic [1:0]   psh_d, psh_q;
  logic [63:0]  pp_d, pp_q;
  logic [127:0] pp_sh;

  // shared units
  logic         gcd_busy, divx_busy, divy_busy;
  logic [127:0] g, qx, qy;

  logic [128:0] sum;
  logic         carry;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == rau_pkg::OP_GCD),
    .a_i     (x_q),
    .b_i     (y_q),
    .busy_o  (gcd_busy),
    .g_o     (g)
  );

  rau_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == rau_pkg::OP_DIV),
    .n_i     (x_q),
    .d_i     (g),
    .busy_o  (divx_busy),
    .q_o     (qx)
  );

  rau_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == rau_pkg::OP_DIV),
    .n_i     (y_q),
    .d_i     (g),
    .busy_o  (divy_busy),
    .q_o     (qy)
  );

  always_comb begin
    case (cmd_i.msel)
      rau_pkg::MS_AN_BD: begin ma_sel = an_q; mb_sel = bd_q;       end
      rau_pkg::MS_BN_AD: begin ma_sel = bn_q; mb_sel = ad_q;       end
      rau_pkg::MS_AD_BD: begin ma_sel = ad_q; mb_sel = bd_q;       end
      rau_pkg::MS_AN_BN: begin ma_sel = an_q; mb_sel = bn_q;       end
      rau_pkg::MS_AN_YL: begin ma_sel = an_q; mb_sel = y_q[63:0];  end
      rau_pkg::MS_BN_XL: begin ma_sel = bn_q; mb_sel = x_q[63:0];  end
      default:           begin ma_sel = an_q; mb_sel = bd_q;       end
    endcase
  end

  // partial products: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    case (mcnt_q)
      3'd0:    begin ma_part = ma_q[31:0];  mb_part = mb_q[31:0];  psh_d = 2'd0; end
      3'd1:    begin ma_part = ma_q[31:0];  mb_part = mb_q[63:32]; psh_d = 2'd1; end
      3'd2:    begin ma_part = ma_q[63:32]; mb_part = mb_q[31:0];  psh_d = 2'd1; end
      default: begin ma_part = ma_q[63:32]; mb_part = mb_q[63:32]; psh_d = 2'd2; end
    endcase
    pp_d = {32'b0, ma_part} * {32'b0, mb_part};
    case (psh_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd1:    pp_sh = {32'b0, pp_q, 32'b0};
      default: pp_sh = {pp_q, 64'b0};
    endcase
  end

  always_comb begin
    sum   = {1'b0, x_q} + {1'b0, y_q};
    carry = |(sum & ~{1'b0, rau_pkg::DMASK});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.op == rau_pkg::OP_MUL) begin
      mbusy_q <= 1'b1;
    end else if (mbusy_q && mcnt_q == 3'd4) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rau_pkg::OP_MUL) begin
      ma_q   <= ma_sel;
      mb_q   <= mb_sel;
      p_q    <= '0;
      mcnt_q <= '0;
    end else if (mbusy_q) begin
      if (mcnt_q != 3'd0) p_q <= p_q + pp_sh;
      if (mcnt_q != 3'd4) begin
        pp_q  <= pp_d;
        psh_q <= psh_d;
      end
      mcnt_q <= mcnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rau_pkg::OP_LOAD: begin
        an_q  <= a_num_i & rau_pkg::WMASK;
        ad_q  <= a_den_i & rau_pkg::WMASK;
        as_q  <= a_sign_i;
        bn_q  <= b_num_i & rau_pkg::WMASK;
        bd_q  <= b_den_i & rau_pkg::WMASK;
        bs_q  <= b_sign_i;
        ovf_q <= 1'b0;
      end
      rau_pkg::OP_MOV_PX: x_q <= p_q;
      rau_pkg::OP_MOV_PY: y_q <= p_q;
      rau_pkg::OP_ADD: begin
        x_q   <= sum[127:0] & rau_pkg::DMASK;
        ovf_q <= carry;
      end
      rau_pkg::OP_SUB: x_q <= (x_q < y_q) ? (y_q - x_q) : (x_q - y_q);
      rau_pkg::OP_FIT: begin
        ovf_q <= ovf_q | (|(x_q & ~{64'b0, rau_pkg::WMASK}))
                       | (|(y_q & ~{64'b0, rau_pkg::WMASK}));
        x_q   <= x_q & {64'b0, rau_pkg::WMASK};
        y_q   <= y_q & {64'b0, rau_pkg::WMASK};
      end
      rau_pkg::OP_MOV_Q: begin
        x_q <= qx;
        y_q <= qy;
      end
      rau_pkg::OP_LD_A: begin
        x_q <= {64'b0, an_q};
        y_q <= {64'b0, ad_q};
      end
      rau_pkg::OP_LD_B: begin
        x_q <= {64'b0, bn_q};
        y_q <= {64'b0, bd_q};
      end
      rau_pkg::OP_LD_BSW: begin
        x_q <= {64'b0, bd_q};
        y_q <= {64'b0, bn_q};
      end
      rau_pkg::OP_LD_DEN: begin
        x_q <= {64'b0, ad_q};
        y_q <= {64'b0, bd_q};
      end
      rau_pkg::OP_ST_A: begin
        an_q <= x_q[63:0];
        ad_q <= y_q[63:0];
      end
      rau_pkg::OP_ST_B: begin
        bn_q <= x_q[63:0];
        bd_q <= y_q[63:0];
      end
      rau_pkg::OP_OUT_RAT: begin
        res_num_o  <= x_q[63:0];
        res_den_o  <= y_q[63:0];
        res_sign_o <= cmd_i.sgn;
        overflow_o <= ovf_q;
        order_o    <= rau_pkg::ORD_EQ;
        equal_o    <= 1'b0;
      end
      rau_pkg::OP_OUT_A: begin
        res_num_o  <= an_q;
        res_den_o  <= ad_q;
        res_sign_o <= as_q;
        overflow_o <= 1'b0;
        order_o    <= rau_pkg::ORD_EQ;
        equal_o    <= 1'b0;
      end
      rau_pkg::OP_OUT_ZERO, rau_pkg::OP_OUT_ORD, rau_pkg::OP_OUT_EQ: begin
        res_num_o  <= '0;
        res_den_o  <= '0;
        res_sign_o <= 1'b0;
        overflow_o <= 1'b0;
        order_o    <= (cmd_i.op == rau_pkg::OP_OUT_ORD) ? cmd_i.ord : rau_pkg::ORD_EQ;
        equal_o    <= (cmd_i.op == rau_pkg::OP_OUT_EQ) && cmd_i.eqb;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.a_sign   = as_q;
    status_o.b_sign   = bs_q;
    status_o.a_nan    = (an_q == '0) && (ad_q == '0);
    status_o.a_inf    = (an_q != '0) && (ad_q == '0);
    status_o.a_zero   = (an_q == '0) && (ad_q != '0);
    status_o.b_nan    = (bn_q == '0) && (bd_q == '0);
    status_o.b_inf    = (bn_q != '0) && (bd_q == '0);
    status_o.b_zero   = (bn_q == '0) && (bd_q != '0);
    status_o.num_eq   = (an_q == bn_q);
    status_o.den_eq   = (ad_q == bd_q);
    status_o.x_lt_y   = (x_q < y_q);
    status_o.x_zero   = (x_q == '0);
    status_o.y_zero   = (y_q == '0);
    status_o.y_gt_p   = (y_q > p_q);
    status_o.y_lt_p   = (y_q < p_q);
    status_o.g_zero   = (g == '0);
    status_o.mul_busy = mbusy_q;
    status_o.gcd_busy = gcd_busy;
    status_o.div_busy = divx_busy | divy_busy;
  end

endmodule
`default_nettype wire

/* src/rau_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer
// Steps the datapath through each operation; holds the output valid flag.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0]       mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rau_pkg::status_t status_i,
  output rau_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_QST, S_RAST, S_RBLD, S_RBST, S_CE,
    S_C5, S_C5W, S_C6, S_C6W,
    S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M4, S_M4W,
    S_FIN, S_FIN2,
    S_RGCD, S_RGW, S_RDIV, S_RDW,
    S_DONE
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [2:0]        mode_q, mode_d;
  logic              effsub_q, effsub_d;
  logic              prod_q, prod_d;
  logic              sgn_q, sgn_d;
  logic              fixz_q, fixz_d;
  logic signed [1:0] ord_q, ord_d;
  logic              eqb_q, eqb_d;
  rau_pkg::dp_op_e   outk_q, outk_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    logic              eff_sub;
    logic signed [1:0] c;
    state_d     = state_q;
    ret_d       = ret_q;
    mode_d      = mode_q;
    effsub_d    = effsub_q;
    prod_d      = prod_q;
    sgn_d       = sgn_q;
    fixz_d      = fixz_q;
    ord_d       = ord_q;
    eqb_d       = eqb_q;
    outk_d      = outk_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = rau_pkg::OP_NONE;
    cmd_o.msel  = rau_pkg::MS_AN_BD;
    cmd_o.sgn   = sgn_q;
    cmd_o.ord   = ord_q;
    cmd_o.eqb   = eqb_q;
    eff_sub     = 1'b0;
    c           = rau_pkg::ORD_EQ;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rau_pkg::OP_LOAD;
          mode_d   = mode_i;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (mode_q)
          rau_pkg::MODE_SUM, rau_pkg::MODE_DIFF: begin
            // opposite signs swap sum and difference
            eff_sub  = (mode_q == rau_pkg::MODE_DIFF) ^ (status_i.a_sign != status_i.b_sign);
            effsub_d = eff_sub;
            prod_d   = 1'b0;
            sgn_d    = status_i.a_sign;
            fixz_d   = eff_sub;
            if (status_i.a_nan || status_i.b_nan) begin
              outk_d  = rau_pkg::OP_OUT_ZERO;
              state_d = S_DONE;
            end else if (status_i.a_inf && status_i.b_inf) begin
              outk_d  = eff_sub ? rau_pkg::OP_OUT_ZERO : rau_pkg::OP_OUT_A;
              state_d = S_DONE;
            end else begin
              state_d = S_M1;
            end
          end
          rau_pkg::MODE_PROD: begin
            prod_d  = 1'b1;
            sgn_d   = status_i.a_sign ^ status_i.b_sign;
            fixz_d  = 1'b1;
            state_d = S_M1;
          end
          rau_pkg::MODE_QUOT: begin
            prod_d = 1'b1;
            fixz_d = 1'b1;
            if (status_i.b_nan) begin
              sgn_d   = status_i.a_sign;
              state_d = S_M1;
            end else begin
              cmd_o.op = rau_pkg::OP_LD_BSW;
              ret_d    = S_QST;
              state_d  = S_RGCD;
            end
          end
          rau_pkg::MODE_CMP, rau_pkg::MODE_EQ: begin
            cmd_o.op = rau_pkg::OP_LD_A;
            ret_d    = S_RAST;
            state_d  = S_RGCD;
          end
          default: begin
            outk_d  = rau_pkg::OP_OUT_ZERO;
            state_d = S_DONE;
          end
        endcase
      end
      S_QST: begin
        cmd_o.op = rau_pkg::OP_ST_B;
        sgn_d    = status_i.a_sign ^ status_i.b_sign;
        state_d  = S_M1;
      end
      S_RAST: begin
        cmd_o.op = rau_pkg::OP_ST_A;
        state_d  = S_RBLD;
      end
      S_RBLD: begin
        cmd_o.op = rau_pkg::OP_LD_B;
        ret_d    = S_RBST;
        state_d  = S_RGCD;
      end
      S_RBST: begin
        cmd_o.op = rau_pkg::OP_ST_B;
        state_d  = S_CE;
      end
      S_CE: begin
        if (mode_q == rau_pkg::MODE_EQ) begin
          eqb_d   = !(status_i.a_nan || status_i.b_nan) &&
                    (status_i.a_sign == status_i.b_sign) &&
                    status_i.num_eq && status_i.den_eq;
          outk_d  = rau_pkg::OP_OUT_EQ;
          state_d = S_DONE;
        end else if (status_i.a_zero && status_i.b_zero) begin
          ord_d   = rau_pkg::ORD_EQ;
          outk_d  = rau_pkg::OP_OUT_ORD;
          state_d = S_DONE;
        end else if (status_i.a_sign != status_i.b_sign) begin
          ord_d   = status_i.a_sign ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
          outk_d  = rau_pkg::OP_OUT_ORD;
          state_d = S_DONE;
        end else begin
          cmd_o.op = rau_pkg::OP_LD_DEN;
          ret_d    = S_C5;
          state_d  = S_RGCD;
        end
      end
      S_C5: begin
        // both denominators zero: the gcd was zero
        if (status_i.x_zero && status_i.y_zero) begin
          ord_d   = rau_pkg::ORD_EQ;
          outk_d  = rau_pkg::OP_OUT_ORD;
          state_d = S_DONE;
        end else begin
          cmd_o.op   = rau_pkg::OP_MUL;
          cmd_o.msel = rau_pkg::MS_AN_YL;
          state_d    = S_C5W;
        end
      end
      S_C5W: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = rau_pkg::OP_MOV_PY;
          state_d  = S_C6;
        end
      end
      S_C6: begin
        cmd_o.op   = rau_pkg::OP_MUL;
        cmd_o.msel = rau_pkg::MS_BN_XL;
        state_d    = S_C6W;
      end
      S_C6W: begin
        if (!status_i.mul_busy) begin
          if (status_i.y_gt_p)      c = rau_pkg::ORD_GT;
          else if (status_i.y_lt_p) c = rau_pkg::ORD_LT;
          else                      c = rau_pkg::ORD_EQ;
          if (status_i.a_sign) begin
            if (c == rau_pkg::ORD_GT)      c = rau_pkg::ORD_LT;
            else if (c == rau_pkg::ORD_LT) c = rau_pkg::ORD_GT;
          end
          ord_d   = c;
          outk_d  = rau_pkg::OP_OUT_ORD;
          state_d = S_DONE;
        end
      end
      S_M1: begin
        cmd_o.op   = rau_pkg::OP_MUL;
        cmd_o.msel = prod_q ? rau_pkg::MS_AN_BN : rau_pkg::MS_AN_BD;
        state_d    = S_M1W;
      end
      S_M1W: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = rau_pkg::OP_MOV_PX;
          state_d  = S_M2;
        end
      end
      S_M2: begin
        cmd_o.op   = rau_pkg::OP_MUL;
        cmd_o.msel = prod_q ? rau_pkg::MS_AD_BD : rau_pkg::MS_BN_AD;
        state_d    = S_M2W;
      end
      S_M2W: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = rau_pkg::OP_MOV_PY;
          state_d  = prod_q ? S_FIN : S_M3;
        end
      end
      S_M3: begin
        cmd_o.op = effsub_q ? rau_pkg::OP_SUB : rau_pkg::OP_ADD;
        if (effsub_q && status_i.x_lt_y) sgn_d = ~sgn_q;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.op   = rau_pkg::OP_MUL;
        cmd_o.msel = rau_pkg::MS_AD_BD;
        state_d    = S_M4W;
      end
      S_M4W: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = rau_pkg::OP_MOV_PY;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        ret_d   = S_FIN2;
        state_d = S_RGCD;
      end
      S_FIN2: begin
        cmd_o.op = rau_pkg::OP_FIT;
        outk_d   = rau_pkg::OP_OUT_RAT;
        ret_d    = S_DONE;
        state_d  = S_RGCD;
      end
      // reduce x/y by their gcd, then return
      S_RGCD: begin
        cmd_o.op = rau_pkg::OP_GCD;
        state_d  = S_RGW;
      end
      S_RGW: begin
        if (!status_i.gcd_busy) state_d = status_i.g_zero ? ret_q : S_RDIV;
      end
      S_RDIV: begin
        cmd_o.op = rau_pkg::OP_DIV;
        state_d  = S_RDW;
      end
      S_RDW: begin
        if (!status_i.div_busy) begin
          cmd_o.op = rau_pkg::OP_MOV_Q;
          state_d  = ret_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = outk_q;
          cmd_o.sgn   = sgn_q & ~(fixz_q & status_i.x_zero & ~status_i.y_zero);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      mode_q      <= rau_pkg::MODE_SUM;
      effsub_q    <= 1'b0;
      prod_q      <= 1'b0;
      sgn_q       <= 1'b0;
      fixz_q      <= 1'b0;
      ord_q       <= rau_pkg::ORD_EQ;
      eqb_q       <= 1'b0;
      outk_q      <= rau_pkg::OP_OUT_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      mode_q      <= mode_d;
      effsub_q    <= effsub_d;
      prod_q      <= prod_d;
      sgn_q       <= sgn_d;
      fixz_q      <= fixz_d;
      ord_q       <= ord_d;
      eqb_q       <= eqb_d;
      outk_q      <= outk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rau_pkg::OP_MUL) |-> !status_i.mul_busy)
    else $error("multiplier restarted while busy");

  a_gcd_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rau_pkg::OP_GCD || cmd_o.op == rau_pkg::OP_DIV) |->
      (!status_i.gcd_busy && !status_i.div_busy))
    else $error("gcd or divider started while busy");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rau_pkg::OP_OUT_RAT || cmd_o.op == rau_pkg::OP_OUT_A ||
     cmd_o.op == rau_pkg::OP_OUT_ZERO || cmd_o.op == rau_pkg::OP_OUT_ORD ||
     cmd_o.op == rau_pkg::OP_OUT_EQ) |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");
`endif

endmodule
`default_nettype wire

/* src/rational_arithmetic_unit_core.sv */
`default_nettype none
// Sums and differences of NaN or of two infinities, and unused modes, skip the
// arithmetic; other results wait on the binary gcd (one shift or subtract per
// cycle on 128 bits) and two parallel dividers, run twice, up to thrice for a
// quotient or compare. Throughput: one transaction in flight; the next is
// accepted once the result sits in the output register. Reset is asynchronous,
// active low, and clears the sequencer, valid flag, gcd unit and busy flags only.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: rational arithmetic unit
// Sum, difference, product, quotient, compare and equals on 64-bit rationals.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .mode_i      (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rau_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_num_i    (in_i.a_num),
    .a_den_i    (in_i.a_den),
    .a_sign_i   (in_i.a_sign),
    .b_num_i    (in_i.b_num),
    .b_den_i    (in_i.b_den),
    .b_sign_i   (in_i.b_sign),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_num_o  (out_o.res_num),
    .res_den_o  (out_o.res_den),
    .res_sign_o (out_o.res_sign),
    .overflow_o (out_o.overflow),
    .order_o    (out_o.order),
    .equal_o    (out_o.equal)
  );

endmodule
`default_nettype wire
